[src/svmrbf_pkg.sv]
`timescale 1ns / 1ps

package svmrbf_pkg;

    // table size and derived widths
    localparam int NUM_VECTORS = 16;
    localparam int VEC_W       = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

    // field widths
    localparam int FEAT_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 24;
    localparam int INDEX_W  = 4;
    localparam int DIST_W   = 34;
    localparam int KERN_W   = 16;

    // accumulator: bias << 16 plus one signed 32 bit product per vector
    localparam int ACC_W = 34 + VEC_W;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

    // command codes
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQA,
        ST_SQB,
        ST_LOOKUP,
        ST_INTERP,
        ST_MAC,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_DIFF,
        OP_SQA,
        OP_SQB,
        OP_LOOKUP,
        OP_INTERP,
        OP_MAC
    } op_t;

    typedef struct packed {
        op_t  op;
        logic clear_acc;
    } ctrl_t;

    // exp(-n/4) in Q0.16, entry zero held at 65535, zero from entry 48 on
    function automatic logic [KERN_W-1:0] exp_lut(input logic [6:0] n);
        logic [KERN_W-1:0] v;
        case (n)
            7'd0:    v = 16'd65535;
            7'd1:    v = 16'd51039;
            7'd2:    v = 16'd39750;
            7'd3:    v = 16'd30957;
            7'd4:    v = 16'd24109;
            7'd5:    v = 16'd18776;
            7'd6:    v = 16'd14623;
            7'd7:    v = 16'd11388;
            7'd8:    v = 16'd8869;
            7'd9:    v = 16'd6907;
            7'd10:   v = 16'd5380;
            7'd11:   v = 16'd4190;
            7'd12:   v = 16'd3263;
            7'd13:   v = 16'd2541;
            7'd14:   v = 16'd1979;
            7'd15:   v = 16'd1541;
            7'd16:   v = 16'd1200;
            7'd17:   v = 16'd935;
            7'd18:   v = 16'd728;
            7'd19:   v = 16'd567;
            7'd20:   v = 16'd442;
            7'd21:   v = 16'd344;
            7'd22:   v = 16'd268;
            7'd23:   v = 16'd209;
            7'd24:   v = 16'd162;
            7'd25:   v = 16'd127;
            7'd26:   v = 16'd99;
            7'd27:   v = 16'd77;
            7'd28:   v = 16'd60;
            7'd29:   v = 16'd47;
            7'd30:   v = 16'd36;
            7'd31:   v = 16'd28;
            7'd32:   v = 16'd22;
            7'd33:   v = 16'd17;
            7'd34:   v = 16'd13;
            7'd35:   v = 16'd10;
            7'd36:   v = 16'd8;
            7'd37:   v = 16'd6;
            7'd38:   v = 16'd5;
            7'd39:   v = 16'd4;
            7'd40:   v = 16'd3;
            7'd41:   v = 16'd2;
            7'd42:   v = 16'd2;
            7'd43:   v = 16'd1;
            7'd44:   v = 16'd1;
            7'd45:   v = 16'd1;
            7'd46:   v = 16'd1;
            7'd47:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[src/svmrbf_dp.sv]
`timescale 1ns / 1ps

module svmrbf_dp (
    input  logic                                   clk,
    input  svmrbf_pkg::ctrl_t                      ctrl,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]   sample_a,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]   sample_b,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]   vec_a,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]   vec_b,
    input  logic signed [svmrbf_pkg::WEIGHT_W-1:0] vec_w,
    input  logic signed [svmrbf_pkg::WEIGHT_W-1:0] bias,
    output logic signed [svmrbf_pkg::SCORE_W-1:0]  score_sat
);
    import svmrbf_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
    localparam longint SHIFT_MAX = longint'(SCORE_MAX);
    localparam longint SHIFT_MIN = longint'(SCORE_MIN);

    logic signed [FEAT_W:0]   da;
    logic signed [FEAT_W:0]   db;
    logic [FEAT_W:0]          ua_next;
    logic [FEAT_W:0]          ub_next;
    logic [FEAT_W:0]          ua_reg;
    logic [FEAT_W:0]          ub_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [KERN_W-1:0]        hi_reg;
    logic [KERN_W-1:0]        diff_reg;
    logic [KERN_W-1:0]        frac_reg;
    logic [KERN_W-1:0]        kern_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [17:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [35:0]       prod;
    logic [32:0]              rnd;

    logic                     far;
    logic [5:0]               lut_idx;
    logic [KERN_W-1:0]        lut_hi;
    logic [KERN_W-1:0]        lut_lo;

    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-17:0] shifted;

    // feature differences and magnitudes
    always_comb
    begin
        da      = {sample_a[FEAT_W-1], sample_a} - {vec_a[FEAT_W-1], vec_a};
        db      = {sample_b[FEAT_W-1], sample_b} - {vec_b[FEAT_W-1], vec_b};
        ua_next = da[FEAT_W] ? ((FEAT_W+1)'(0) - da) : da;
        ub_next = db[FEAT_W] ? ((FEAT_W+1)'(0) - db) : db;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (ctrl.op)
            OP_SQA:
            begin
                mul_a = {1'b0, ua_reg};
                mul_b = {1'b0, ua_reg};
            end
            OP_SQB:
            begin
                mul_a = {1'b0, ub_reg};
                mul_b = {1'b0, ub_reg};
            end
            OP_INTERP:
            begin
                mul_a = {2'b00, diff_reg};
                mul_b = {2'b00, frac_reg};
            end
            OP_MAC:
            begin
                mul_a = {{2{w_reg[WEIGHT_W-1]}}, w_reg};
                mul_b = {2'b00, kern_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign rnd  = prod[32:0] + 33'd32768;

    // table segment from squared distance, steps of 1/4
    assign far     = |dist_reg[DIST_W-1:24];
    assign lut_idx = dist_reg[23:18];
    assign lut_hi  = exp_lut({1'b0, lut_idx});
    assign lut_lo  = exp_lut({1'b0, lut_idx} + 7'd1);

    // sequenced datapath registers
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_DIFF:
            begin
                ua_reg <= ua_next;
                ub_reg <= ub_next;
                w_reg  <= vec_w;
            end
            OP_SQA:
            begin
                dist_reg <= prod[DIST_W-1:0];
            end
            OP_SQB:
            begin
                dist_reg <= dist_reg + prod[DIST_W-1:0];
            end
            OP_LOOKUP:
            begin
                if (far)
                begin
                    hi_reg   <= '0;
                    diff_reg <= '0;
                end
                else
                begin
                    hi_reg   <= lut_hi;
                    diff_reg <= lut_hi - lut_lo;
                end
                frac_reg <= dist_reg[17:2];
            end
            OP_INTERP:
            begin
                kern_reg <= hi_reg - rnd[31:16];
            end
            OP_MAC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
            end
            default:
            begin
            end
        endcase
        if (ctrl.clear_acc)
        begin
            acc_reg <= ACC_W'(bias) <<< 16;
        end
    end

    // round to Q.14 and saturate
    always_comb
    begin
        rounded = acc_reg + ROUND_HALF;
        shifted = $signed(rounded[ACC_W-1:16]);
        if (longint'(shifted) > SHIFT_MAX)
        begin
            score_sat = SCORE_MAX;
        end
        else if (longint'(shifted) < SHIFT_MIN)
        begin
            score_sat = SCORE_MIN;
        end
        else
        begin
            score_sat = SCORE_W'(shifted);
        end
    end

endmodule

[src/svm_rbf_kernel_classifier.sv]
`timescale 1ns / 1ps

// Gaussian kernel SVM scorer over two features.
// Input channel (in_valid/in_ready): cmd selects a load or a classify request.
// A load request writes feature_a, feature_b and weight into slot entry_index
// of a 16 entry table and produces no result.
// A classify request carries a sample in feature_a/feature_b and returns one
// result (score, positive_class) on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the bias; it is
// always ready and should be written while no classify request is in flight.
// A classify request works through each table entry in turn (difference,
// two squares, table lookup, interpolation, multiply-accumulate on one shared
// 18x18 multiplier), then rounds and loads the result in a final step.
// in_ready is low while a classify request is worked on.
// The result sits in an output register; if the receiver stalls, the next
// result waits in the final step until that register frees up, while load
// requests queued behind are taken once the block returns to idle.
// Reset clears the table (all entries read as zero), the bias and all
// handshake state.
module svm_rbf_kernel_classifier (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic signed [svmrbf_pkg::WEIGHT_W-1:0]  cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    cmd,
    input  logic [svmrbf_pkg::INDEX_W-1:0]          entry_index,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]    feature_a,
    input  logic signed [svmrbf_pkg::FEAT_W-1:0]    feature_b,
    input  logic signed [svmrbf_pkg::WEIGHT_W-1:0]  weight,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [svmrbf_pkg::SCORE_W-1:0]   score,
    output logic                                    positive_class
);
    import svmrbf_pkg::*;

    localparam logic [VEC_W-1:0] LAST_VEC = VEC_W'(NUM_VECTORS - 1);

    state_t                     state_reg;
    state_t                     state_next;
    logic [VEC_W-1:0]           vec_idx_reg;
    logic [VEC_W-1:0]           vec_idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [WEIGHT_W-1:0] bias_reg;

    logic signed [FEAT_W-1:0]   tab_a_reg [NUM_VECTORS];
    logic signed [FEAT_W-1:0]   tab_b_reg [NUM_VECTORS];
    logic signed [WEIGHT_W-1:0] tab_w_reg [NUM_VECTORS];
    logic [NUM_VECTORS-1:0]     tab_valid_reg;

    logic signed [FEAT_W-1:0]   sample_a_reg;
    logic signed [FEAT_W-1:0]   sample_b_reg;
    logic signed [SCORE_W-1:0]  score_reg;
    logic                       class_reg;

    logic                       in_fire;
    logic                       load_fire;
    logic                       load_in_range;
    logic [VEC_W-1:0]           wr_idx;
    logic                       out_load;
    ctrl_t                      ctrl;

    logic signed [FEAT_W-1:0]   vec_a;
    logic signed [FEAT_W-1:0]   vec_b;
    logic signed [WEIGHT_W-1:0] vec_w;
    logic signed [SCORE_W-1:0]  score_sat;

    assign in_fire       = in_valid && in_ready;
    assign load_in_range = {5'd0, entry_index} < 9'(NUM_VECTORS);
    assign load_fire     = in_fire && (cmd == CMD_LOAD) && load_in_range;
    assign wr_idx        = VEC_W'(entry_index);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        vec_idx_next = vec_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_CLASSIFY))
                begin
                    state_next   = ST_DIFF;
                    vec_idx_next = '0;
                end
            end
            ST_DIFF:   state_next = ST_SQA;
            ST_SQA:    state_next = ST_SQB;
            ST_SQB:    state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_INTERP;
            ST_INTERP: state_next = ST_MAC;
            ST_MAC:
            begin
                if (vec_idx_reg == LAST_VEC)
                begin
                    state_next   = ST_FINISH;
                    vec_idx_next = '0;
                end
                else
                begin
                    state_next   = ST_DIFF;
                    vec_idx_next = vec_idx_reg + VEC_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_load       = 1'b0;
        ctrl.op        = OP_HOLD;
        ctrl.clear_acc = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.clear_acc = in_valid && (cmd == CMD_CLASSIFY);
            end
            ST_DIFF:   ctrl.op = OP_DIFF;
            ST_SQA:    ctrl.op = OP_SQA;
            ST_SQB:    ctrl.op = OP_SQB;
            ST_LOOKUP: ctrl.op = OP_LOOKUP;
            ST_INTERP: ctrl.op = OP_INTERP;
            ST_MAC:    ctrl.op = OP_MAC;
            ST_FINISH: out_load = !out_valid_reg || out_ready;
            default:
            begin
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vec_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            bias_reg      <= '0;
            tab_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vec_idx_reg   <= vec_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                bias_reg <= cfg_data;
            end
            if (load_fire)
            begin
                tab_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // support vector table and sample capture
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            tab_a_reg[wr_idx] <= feature_a;
            tab_b_reg[wr_idx] <= feature_b;
            tab_w_reg[wr_idx] <= weight;
        end
        if (in_fire && (cmd == CMD_CLASSIFY))
        begin
            sample_a_reg <= feature_a;
            sample_b_reg <= feature_b;
        end
        if (out_load)
        begin
            score_reg <= score_sat;
            class_reg <= !score_sat[SCORE_W-1];
        end
    end

    // entries never written read as zero
    always_comb
    begin
        if (tab_valid_reg[vec_idx_reg])
        begin
            vec_a = tab_a_reg[vec_idx_reg];
            vec_b = tab_b_reg[vec_idx_reg];
            vec_w = tab_w_reg[vec_idx_reg];
        end
        else
        begin
            vec_a = '0;
            vec_b = '0;
            vec_w = '0;
        end
    end

    svmrbf_dp u_dp (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample_a  (sample_a_reg),
        .sample_b  (sample_b_reg),
        .vec_a     (vec_a),
        .vec_b     (vec_b),
        .vec_w     (vec_w),
        .bias      (bias_reg),
        .score_sat (score_sat)
    );

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign score          = score_reg;
    assign positive_class = class_reg;

    // classify request starts the sweep at the first entry
    a_classify_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_CLASSIFY)
        |=> (state_reg == ST_DIFF) && (vec_idx_reg == '0))
        else $error("classify request did not start at entry zero");

    // sweep ends after the last entry
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) && (vec_idx_reg == LAST_VEC) |=> state_reg == ST_FINISH)
        else $error("sweep did not finish after last entry");

    // finished score lands in the output register
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && (!out_valid_reg || out_ready)
        |=> out_valid && (state_reg == ST_IDLE))
        else $error("result not presented after finish");

    // class follows the sign of the score
    a_class_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> positive_class == !score[SCORE_W-1])
        else $error("class does not match score sign");

endmodule
